// ===== design/direct_conv2d_batched_defines.svh =====
// Assertion macros for the checker file of direct_conv2d_batched.
// Depends on nothing; included by bare file name.
`ifndef DIRECT_CONV2D_BATCHED_DEFINES_SVH
`define DIRECT_CONV2D_BATCHED_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DCB_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("dcb assertion failed");

// Next-cycle implication, disabled during reset
`define DCB_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("dcb assertion failed");

`endif

// ===== design/dcb_pkg.sv =====
// Shared types, codes and defaults of the batched 2-D convolution block.
// Depends on nothing; imported by every module of the block but dcb_ram.
package dcb_pkg;

  // Default sizes of the stores and arithmetic
  localparam int DEF_IN_DEPTH     = 4096;
  localparam int DEF_WEIGHT_DEPTH = 4096;
  localparam int DEF_OUT_DEPTH    = 4096;
  localparam int DEF_DATA_WIDTH   = 16;
  localparam int DEF_ACC_WIDTH    = 48;

  // Fixed field widths
  localparam int INDEX_W  = 12;
  localparam int VALUE_W  = 16;
  localparam int RESULT_W = 48;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_LOAD_IN  = 2'd0,
    KIND_LOAD_W   = 2'd1,
    KIND_RUN      = 2'd2,
    KIND_READ     = 2'd3
  } kind_t;

  // Register indexes
  typedef enum logic [2:0] {
    REG_BATCH    = 3'd0,
    REG_IN_CH    = 3'd1,
    REG_OUT_CH   = 3'd2,
    REG_OUT_ROWS = 3'd3,
    REG_OUT_COLS = 3'd4,
    REG_KERNEL   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [4:0] batch_size;
    logic [4:0] in_channels;
    logic [4:0] out_channels;
    logic [5:0] out_rows;
    logic [5:0] out_cols;
    logic [2:0] kernel_size;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE1,
    ST_SIZE2,
    ST_MAC,
    ST_DRAIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_in;
    logic wr_w;
    logic rd_out;
    logic load_out;
    logic init;
    logic step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic size_bad;
    logic empty;
    logic all_last;
    logic pipe_busy;
  } sts_t;

endpackage

// ===== design/dcb_if.sv =====
// Valid/ready channel interfaces for item words and result words.
// Depends on dcb_pkg for the field widths.
interface dcb_in_if;
  import dcb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [INDEX_W-1:0]        index;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, output kind, output index, output value, input ready);
  modport sink   (input valid, input kind, input index, input value, output ready);
endinterface

interface dcb_out_if;
  import dcb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] result_value;
  logic                       size_error;
  modport source (output valid, output result_value, output size_error, input ready);
  modport sink   (input valid, input result_value, input size_error, output ready);
endinterface

// ===== design/direct_conv2d_batched.sv =====
// Words are taken only in idle; a read result passes the registered output
// store port and the result register, and no word is taken until it shows.
// A run checks sizes, ends if a size is bad or zero, else does one
// multiply-accumulate per step over all Ro*Co*No*B*K*K*Ni products, then
// drains the MAC pipe. Reset is synchronous; a fill count makes the output
// store read zero without clearing; input and weight stores start unknown.
module direct_conv2d_batched #(
  parameter int IN_DEPTH     = dcb_pkg::DEF_IN_DEPTH,
  parameter int WEIGHT_DEPTH = dcb_pkg::DEF_WEIGHT_DEPTH,
  parameter int OUT_DEPTH    = dcb_pkg::DEF_OUT_DEPTH,
  parameter int DATA_WIDTH   = dcb_pkg::DEF_DATA_WIDTH,
  parameter int ACC_WIDTH    = dcb_pkg::DEF_ACC_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  dcb_in_if.sink                      in_ch,
  dcb_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dcb_pkg::PADDR_W-1:0] paddr,
  input  logic [dcb_pkg::PDATA_W-1:0] pwdata,
  output logic [dcb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import dcb_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  dcb_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  dcb_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_kind(in_ch.kind), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  dcb_datapath #(
    .IN_DEPTH(IN_DEPTH), .WEIGHT_DEPTH(WEIGHT_DEPTH), .OUT_DEPTH(OUT_DEPTH),
    .DATA_WIDTH(DATA_WIDTH), .ACC_WIDTH(ACC_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd),
    .index(in_ch.index), .value(in_ch.value), .sts(sts),
    .result_value(out_ch.result_value), .size_error(out_ch.size_error)
  );
endmodule

// ===== design/dcb_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module dcb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/dcb_regs.sv =====
// APB-style configuration registers of the convolution block.
// Depends on dcb_pkg for cfg_t and register indexes.
module dcb_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [dcb_pkg::PADDR_W-1:0] paddr,
  input  logic [dcb_pkg::PDATA_W-1:0] pwdata,
  output logic [dcb_pkg::PDATA_W-1:0] prdata,
  output logic                   pready,
  output dcb_pkg::cfg_t          cfg
);
  import dcb_pkg::*;

  logic     wr_en;
  reg_idx_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = reg_idx_t'(paddr[PADDR_W-1:2]);

  // Write the addressed register, drop writes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.batch_size   <= 5'd1;
      cfg.in_channels  <= 5'd1;
      cfg.out_channels <= 5'd1;
      cfg.out_rows     <= 6'd1;
      cfg.out_cols     <= 6'd1;
      cfg.kernel_size  <= 3'd1;
    end else if (wr_en) begin
      unique case (sel)
        REG_BATCH:    cfg.batch_size   <= pwdata[4:0];
        REG_IN_CH:    cfg.in_channels  <= pwdata[4:0];
        REG_OUT_CH:   cfg.out_channels <= pwdata[4:0];
        REG_OUT_ROWS: cfg.out_rows     <= pwdata[5:0];
        REG_OUT_COLS: cfg.out_cols     <= pwdata[5:0];
        REG_KERNEL:   cfg.kernel_size  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    unique case (sel)
      REG_BATCH:    prdata = PDATA_W'(cfg.batch_size);
      REG_IN_CH:    prdata = PDATA_W'(cfg.in_channels);
      REG_OUT_CH:   prdata = PDATA_W'(cfg.out_channels);
      REG_OUT_ROWS: prdata = PDATA_W'(cfg.out_rows);
      REG_OUT_COLS: prdata = PDATA_W'(cfg.out_cols);
      REG_KERNEL:   prdata = PDATA_W'(cfg.kernel_size);
      default:      prdata = '0;
    endcase
  end
endmodule

// ===== design/dcb_ctrl.sv =====
// Controller: handshake, run sequencing and result word control.
// Depends on dcb_pkg for state_t, cmd_t and sts_t.
module dcb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    in_kind,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  dcb_pkg::sts_t sts,
  output dcb_pkg::cmd_t cmd
);
  import dcb_pkg::*;

  state_t state, state_next;
  logic   rd_pend;
  logic   accept;
  kind_t  kind;

  assign kind     = kind_t'(in_kind);
  assign in_ready = (state == ST_IDLE) && !rd_pend && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Hold state, read pending flag and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= cmd.rd_out;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.load_out = rd_pend;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_LOAD_IN: cmd.wr_in  = 1'b1;
            KIND_LOAD_W:  cmd.wr_w   = 1'b1;
            KIND_RUN:     state_next = ST_SIZE1;
            KIND_READ:    cmd.rd_out = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SIZE1: state_next = ST_SIZE2;
      ST_SIZE2: begin
        cmd.init   = 1'b1;
        state_next = (sts.size_bad || sts.empty) ? ST_IDLE : ST_MAC;
      end
      ST_MAC: begin
        cmd.step = 1'b1;
        if (sts.all_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== design/dcb_datapath.sv =====
// Datapath: stores, size check, address walk and multiply-accumulate pipe.
// Depends on dcb_pkg and dcb_ram.
module dcb_datapath #(
  parameter int IN_DEPTH     = dcb_pkg::DEF_IN_DEPTH,
  parameter int WEIGHT_DEPTH = dcb_pkg::DEF_WEIGHT_DEPTH,
  parameter int OUT_DEPTH    = dcb_pkg::DEF_OUT_DEPTH,
  parameter int DATA_WIDTH   = dcb_pkg::DEF_DATA_WIDTH,
  parameter int ACC_WIDTH    = dcb_pkg::DEF_ACC_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dcb_pkg::cfg_t                       cfg,
  input  dcb_pkg::cmd_t                       cmd,
  input  logic [dcb_pkg::INDEX_W-1:0]         index,
  input  logic signed [dcb_pkg::VALUE_W-1:0]  value,
  output dcb_pkg::sts_t                       sts,
  output logic signed [dcb_pkg::RESULT_W-1:0] result_value,
  output logic                                size_error
);
  import dcb_pkg::*;

  localparam int IAW = $clog2(IN_DEPTH);
  localparam int WAW = $clog2(WEIGHT_DEPTH);
  localparam int OAW = $clog2(OUT_DEPTH);
  localparam int FW  = $clog2(OUT_DEPTH + 1);
  localparam int PW  = 2 * DATA_WIDTH;

  // Size check, first stage
  logic [6:0]  ri, ci;
  logic [13:0] ri_ci;
  logic [9:0]  ni_b, no_ni, no_b;
  logic [5:0]  k_k;
  logic [11:0] ro_co;
  logic [6:0]  ci_q;
  logic [2:0]  k_q;
  // Size check, second stage
  logic [23:0] in_sz;
  logic [15:0] w_sz;
  logic [21:0] o_sz;
  logic [IAW-1:0] s_bni, s_row;
  logic [WAW-1:0] w_col, w_row;
  logic           empty_q;

  // Loop counters
  logic [5:0] r, c;
  logic [4:0] o, b, i;
  logic [2:0] kr, kc;
  logic last_r, last_c, last_o, last_b, last_kr, last_kc, last_i;

  // Address walk
  logic [IAW-1:0] in_r, in_rc, in_ob, in_kr, in_kc, in_addr;
  logic [WAW-1:0] w_o, w_kr, w_kc, w_addr;

  // Pipe
  logic s1_v, s1_first, s1_last, s2_v, s2_first, s2_last;
  logic [DATA_WIDTH-1:0] x_q, w_q;
  logic signed [PW-1:0]  prod;
  logic signed [ACC_WIDTH-1:0] acc, sum;

  // Stores and control state
  logic [FW-1:0]        fill;
  logic                 err_flag;
  logic                 rd_ok;
  logic [ACC_WIDTH-1:0] o_q;
  logic                 in_we, w_we, out_we;
  logic [DATA_WIDTH-1:0] wr_val;

  assign ri = (cfg.kernel_size == 3'd0) ? 7'(cfg.out_rows)
            : 7'(cfg.out_rows) + 7'(cfg.kernel_size) - 7'd1;
  assign ci = (cfg.kernel_size == 3'd0) ? 7'(cfg.out_cols)
            : 7'(cfg.out_cols) + 7'(cfg.kernel_size) - 7'd1;

  // Register the pair products of the configuration
  always_ff @(posedge clk) begin
    ri_ci <= ri * ci;
    ni_b  <= cfg.in_channels * cfg.batch_size;
    k_k   <= cfg.kernel_size * cfg.kernel_size;
    no_ni <= cfg.out_channels * cfg.in_channels;
    ro_co <= cfg.out_rows * cfg.out_cols;
    no_b  <= cfg.out_channels * cfg.batch_size;
    ci_q  <= ci;
    k_q   <= cfg.kernel_size;
  end

  // Register the store sizes, strides and empty test
  always_ff @(posedge clk) begin
    in_sz <= ri_ci * ni_b;
    w_sz  <= k_k * no_ni;
    o_sz  <= ro_co * no_b;
    s_bni <= IAW'(ni_b);
    s_row <= IAW'(24'(ni_b) * 24'(ci_q));
    w_col <= WAW'(no_ni);
    w_row <= WAW'(16'(no_ni) * 16'(k_q));
    empty_q <= (cfg.batch_size == 5'd0) || (cfg.in_channels == 5'd0) ||
               (cfg.out_channels == 5'd0) || (cfg.out_rows == 6'd0) ||
               (cfg.out_cols == 6'd0) || (cfg.kernel_size == 3'd0);
  end

  assign sts.empty    = empty_q;
  assign sts.size_bad = (32'(in_sz) > IN_DEPTH) || (32'(w_sz) > WEIGHT_DEPTH) ||
                        (32'(o_sz) > OUT_DEPTH);

  assign last_i  = (i  == cfg.in_channels - 5'd1);
  assign last_kc = (kc == cfg.kernel_size - 3'd1);
  assign last_kr = (kr == cfg.kernel_size - 3'd1);
  assign last_b  = (b  == cfg.batch_size - 5'd1);
  assign last_o  = (o  == cfg.out_channels - 5'd1);
  assign last_c  = (c  == cfg.out_cols - 6'd1);
  assign last_r  = (r  == cfg.out_rows - 6'd1);
  assign sts.all_last = last_i && last_kc && last_kr && last_b && last_o && last_c && last_r;
  assign sts.pipe_busy = s1_v || s2_v;

  // Advance the loop nest and its addresses, one product a step
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      {r, c, o, b, kr, kc, i} <= '0;
      {in_r, in_rc, in_ob, in_kr, in_kc, in_addr} <= '0;
      {w_o, w_kr, w_kc, w_addr} <= '0;
    end else if (cmd.step) begin
      if (!last_i) begin
        i       <= i + 5'd1;
        in_addr <= in_addr + IAW'(cfg.batch_size);
        w_addr  <= w_addr + WAW'(1);
      end else if (!last_kc) begin
        i       <= '0;
        kc      <= kc + 3'd1;
        in_kc   <= in_kc + s_bni;
        in_addr <= in_kc + s_bni;
        w_kc    <= w_kc + w_col;
        w_addr  <= w_kc + w_col;
      end else if (!last_kr) begin
        i       <= '0;
        kc      <= '0;
        kr      <= kr + 3'd1;
        in_kr   <= in_kr + s_row;
        in_kc   <= in_kr + s_row;
        in_addr <= in_kr + s_row;
        w_kr    <= w_kr + w_row;
        w_kc    <= w_kr + w_row;
        w_addr  <= w_kr + w_row;
      end else begin
        {kr, kc, i} <= '0;
        if (!last_b) begin
          b <= b + 5'd1;
          in_ob   <= in_ob + IAW'(1);
          in_kr   <= in_ob + IAW'(1);
          in_kc   <= in_ob + IAW'(1);
          in_addr <= in_ob + IAW'(1);
          w_kr    <= w_o;
          w_kc    <= w_o;
          w_addr  <= w_o;
        end else if (!last_o) begin
          b <= '0;
          o <= o + 5'd1;
          in_ob   <= in_rc;
          in_kr   <= in_rc;
          in_kc   <= in_rc;
          in_addr <= in_rc;
          w_o     <= w_o + WAW'(cfg.in_channels);
          w_kr    <= w_o + WAW'(cfg.in_channels);
          w_kc    <= w_o + WAW'(cfg.in_channels);
          w_addr  <= w_o + WAW'(cfg.in_channels);
        end else begin
          b <= '0;
          o <= '0;
          {w_o, w_kr, w_kc, w_addr} <= '0;
          if (!last_c) begin
            c <= c + 6'd1;
            in_rc   <= in_rc + s_bni;
            in_ob   <= in_rc + s_bni;
            in_kr   <= in_rc + s_bni;
            in_kc   <= in_rc + s_bni;
            in_addr <= in_rc + s_bni;
          end else begin
            c <= '0;
            r <= r + 6'd1;
            in_r    <= in_r + s_row;
            in_rc   <= in_r + s_row;
            in_ob   <= in_r + s_row;
            in_kr   <= in_r + s_row;
            in_kc   <= in_r + s_row;
            in_addr <= in_r + s_row;
          end
        end
      end
    end
  end

  // Stores
  assign wr_val = DATA_WIDTH'(value);
  assign in_we  = cmd.wr_in && (32'(index) < IN_DEPTH);
  assign w_we   = cmd.wr_w && (32'(index) < WEIGHT_DEPTH);

  dcb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(IN_DEPTH)) u_in_ram (
    .clk(clk), .we(in_we), .waddr(IAW'(index)), .wdata(wr_val),
    .raddr(in_addr), .rdata(x_q)
  );

  dcb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(WEIGHT_DEPTH)) u_w_ram (
    .clk(clk), .we(w_we), .waddr(WAW'(index)), .wdata(wr_val),
    .raddr(w_addr), .rdata(w_q)
  );

  dcb_ram #(.WIDTH(ACC_WIDTH), .DEPTH(OUT_DEPTH)) u_out_ram (
    .clk(clk), .we(out_we), .waddr(OAW'(fill)), .wdata(sum),
    .raddr(OAW'(index)), .rdata(o_q)
  );

  // Pipe control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= cmd.step;
      s2_v <= s1_v;
    end
  end

  // Multiply, then accumulate
  always_ff @(posedge clk) begin
    s1_first <= (i == 5'd0) && (kc == 3'd0) && (kr == 3'd0);
    s1_last  <= last_i && last_kc && last_kr;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    prod     <= $signed(x_q) * $signed(w_q);
    if (s2_v) begin
      acc <= sum;
    end
  end

  assign sum    = (s2_first ? '0 : acc) + ACC_WIDTH'(prod);
  assign out_we = s2_v && s2_last;

  // Fill count and error flag; entries at or past the count read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      err_flag <= 1'b0;
    end else if (cmd.init) begin
      fill     <= '0;
      err_flag <= sts.size_bad;
    end else if (out_we) begin
      fill <= fill + FW'(1);
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.rd_out) begin
      rd_ok <= (32'(index) < OUT_DEPTH) && (32'(index) < 32'(fill));
    end
    if (cmd.load_out) begin
      result_value <= rd_ok ? RESULT_W'($signed(o_q)) : '0;
      size_error   <= err_flag;
    end
  end
endmodule

// ===== design/dcb_checker.sv =====
// Port-level checker for direct_conv2d_batched, attached by bind.
// Depends on dcb_pkg and direct_conv2d_batched_defines.svh.
`include "direct_conv2d_batched_defines.svh"
module dcb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [1:0]                   in_kind,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dcb_pkg::RESULT_W-1:0] result_value
);
  import dcb_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled result word holds
  `DCB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result_value))
  // A read shows its result after the read-pending and result-valid registers
  `DCB_ASSERT_IMPL(a_read_lat, clk, rst, in_acc && (in_kind == KIND_READ), ##2 out_valid)
  // A run blocks new words right away
  `DCB_ASSERT_NEXT(a_run_busy, clk, rst, in_acc && (in_kind == KIND_RUN), !in_ready)
  // No word is taken while a result waits unread
  `DCB_ASSERT_IMPL(a_no_take, clk, rst, out_valid && !out_ready, !in_ready)
endmodule

bind direct_conv2d_batched dcb_checker u_dcb_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.kind),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .result_value(out_ch.result_value)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the batched 2-D convolution block.
// Depends on dcb_pkg and the dcb_in_if / dcb_out_if channel interfaces.
module testbench;
  import dcb_pkg::*;

  typedef struct {
    logic [47:0] value;
    logic        flag;
  } read_word_t;

  // Scoreboard: holds its own copy of the stores and registers
  class conv_scoreboard;
    logic [15:0] in_mem [0:4095];
    logic [15:0] w_mem  [0:4095];
    logic [47:0] out_mem[0:4095];
    logic        err_flag;
    int          dim[6];
    read_word_t  pending_reads[$];
    int          errors;

    function new();
      foreach (out_mem[i]) out_mem[i] = '0;
      foreach (in_mem[i]) begin
        in_mem[i] = '0;
        w_mem[i]  = '0;
      end
      err_flag = 1'b0;
      foreach (dim[i]) dim[i] = 1;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t r, int v);
      case (r)
        REG_OUT_ROWS, REG_OUT_COLS: dim[r] = v & 63;
        REG_KERNEL:                 dim[r] = v & 7;
        default:                    dim[r] = v & 31;
      endcase
    endfunction

    function void convolve();
      int b_n, ni, no, ro, co, k, ri, ci;
      longint acc, x, w;
      b_n = dim[REG_BATCH]; ni = dim[REG_IN_CH]; no = dim[REG_OUT_CH];
      ro = dim[REG_OUT_ROWS]; co = dim[REG_OUT_COLS]; k = dim[REG_KERNEL];
      ri = (k == 0) ? ro : ro + k - 1;
      ci = (k == 0) ? co : co + k - 1;
      foreach (out_mem[i]) out_mem[i] = '0;
      if (ri * ci * ni * b_n > 4096 || k * k * no * ni > 4096 || ro * co * no * b_n > 4096) begin
        err_flag = 1'b1;
        return;
      end
      err_flag = 1'b0;
      for (int r = 0; r < ro; r++)
        for (int c = 0; c < co; c++)
          for (int o = 0; o < no; o++)
            for (int b = 0; b < b_n; b++) begin
              acc = 0;
              for (int kr = 0; kr < k; kr++)
                for (int kc = 0; kc < k; kc++)
                  for (int i = 0; i < ni; i++) begin
                    x = $signed(in_mem[b + b_n * (i + ni * ((c + kc) + ci * (r + kr)))]);
                    w = $signed(w_mem[i + ni * (o + no * (kc + k * kr))]);
                    acc += x * w;
                  end
              out_mem[b + b_n * (o + no * (c + co * r))] = acc[47:0];
            end
    endfunction

    // Note an accepted item word
    function void note_item(kind_t kd, logic [11:0] idx, logic [15:0] val);
      read_word_t rw;
      case (kd)
        KIND_LOAD_IN: in_mem[idx] = val;
        KIND_LOAD_W:  w_mem[idx] = val;
        KIND_RUN:     convolve();
        default: begin
          rw.value = out_mem[idx];
          rw.flag  = err_flag;
          pending_reads.push_back(rw);
        end
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Check a result word against the oldest expectation
    task check_result(logic [47:0] val, logic flag);
      read_word_t rw;
      if (pending_reads.size() == 0) begin
        report($sformatf("unexpected result %h/%b", val, flag));
        return;
      end
      rw = pending_reads.pop_front();
      if (val !== rw.value)
        report($sformatf("result_value %h, want %h", val, rw.value));
      if (flag !== rw.flag)
        report($sformatf("size_error %b, want %b", flag, rw.flag));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic        pready;

  dcb_in_if  in_ch();
  dcb_out_if out_ch();

  direct_conv2d_batched dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  conv_scoreboard sb;
  int  send_gap_pct;
  int  stall_pct;
  int  hold_cnt;
  logic hold_req;
  int  cycles;
  bit  in_done[0:4095];
  bit  w_done[0:4095];
  int  last_run_cycles;

  localparam int CYCLE_LIMIT = 5000000;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    sb = new();
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.kind = KIND_LOAD_IN; in_ch.index = '0; in_ch.value = '0;
    out_ch.ready = 1'b0;
    send_gap_pct = 0; stall_pct = 0; hold_cnt = 0; hold_req = 1'b0; cycles = 0;
    last_run_cycles = 0;
    foreach (in_done[i]) begin
      in_done[i] = 1'b0;
      w_done[i]  = 1'b0;
    end
  end

  // Abort on a runaway run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Drive receiver ready, with random stalls and a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt <= 400;
      hold_req <= 1'b0;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watch both channels
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      sb.note_item(kind_t'(in_ch.kind), in_ch.index, in_ch.value);
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.result_value, out_ch.size_error);
  end

  task apb_write(reg_idx_t r, int v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * r); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(r, v);
  endtask

  // Offer one word and hold it until accepted
  task send_word(kind_t kd, int idx, int val);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kd;
    in_ch.index <= idx[11:0];
    in_ch.value <= val[15:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (kd == KIND_LOAD_IN) in_done[idx] = 1'b1;
    if (kd == KIND_LOAD_W)  w_done[idx] = 1'b1;
  endtask

  function int pick_value();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Sizes of the used input and weight regions and the MAC count; all zero if a size overflows its store
  function void used_sizes(output int n_in, output int n_w, output int macs);
    int ri, ci, k;
    k = sb.dim[REG_KERNEL];
    ri = (k == 0) ? sb.dim[REG_OUT_ROWS] : sb.dim[REG_OUT_ROWS] + k - 1;
    ci = (k == 0) ? sb.dim[REG_OUT_COLS] : sb.dim[REG_OUT_COLS] + k - 1;
    n_in = ri * ci * sb.dim[REG_IN_CH] * sb.dim[REG_BATCH];
    n_w  = k * k * sb.dim[REG_OUT_CH] * sb.dim[REG_IN_CH];
    macs = sb.dim[REG_OUT_ROWS] * sb.dim[REG_OUT_COLS] * sb.dim[REG_OUT_CH] *
           sb.dim[REG_BATCH];
    if (n_in > 4096 || n_w > 4096 || macs > 4096) begin
      n_in = 0; n_w = 0; macs = 0;
    end else begin
      macs = macs * k * k * sb.dim[REG_IN_CH];
    end
  endfunction

  // Fill any used entry never written, then start a run
  task start_run();
    int n_in, n_w, macs;
    used_sizes(n_in, n_w, macs);
    for (int i = 0; i < n_in; i++)
      if (!in_done[i]) send_word(KIND_LOAD_IN, i, pick_value());
    for (int i = 0; i < n_w; i++)
      if (!w_done[i]) send_word(KIND_LOAD_W, i, pick_value());
    send_word(KIND_RUN, $urandom_range(0, 4095), $urandom_range(0, 65535));
    last_run_cycles = macs + 5;
  endtask

  task random_items(int count);
    int n_in, n_w, macs, n_out, sel;
    used_sizes(n_in, n_w, macs);
    n_out = sb.dim[REG_OUT_ROWS] * sb.dim[REG_OUT_COLS] * sb.dim[REG_OUT_CH] *
            sb.dim[REG_BATCH];
    if (n_out < 1) n_out = 1;
    if (n_out > 4096) n_out = 4096;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 18)
        send_word(KIND_LOAD_IN, ($urandom_range(0, 3) == 0 || n_in == 0) ?
                  $urandom_range(0, 4095) : $urandom_range(0, n_in - 1), pick_value());
      else if (sel < 36)
        send_word(KIND_LOAD_W, ($urandom_range(0, 3) == 0 || n_w == 0) ?
                  $urandom_range(0, 4095) : $urandom_range(0, n_w - 1), pick_value());
      else if (sel < 43)
        start_run();
      else
        send_word(KIND_READ, ($urandom_range(0, 4) == 0) ?
                  $urandom_range(0, 4095) : $urandom_range(0, n_out - 1), 0);
    end
  endtask

  // Drop valid and hold until all reads are back and any run has drained
  task settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (last_run_cycles + 20) @(posedge clk);
  endtask

  task set_config(int b, int ni, int no, int ro, int co, int k);
    apb_write(REG_BATCH, b);
    apb_write(REG_IN_CH, ni);
    apb_write(REG_OUT_CH, no);
    apb_write(REG_OUT_ROWS, ro);
    apb_write(REG_OUT_COLS, co);
    apb_write(REG_KERNEL, k);
  endtask

  initial begin
    int phase;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset sizes, value extremes, edge indexes, every kind
    send_word(KIND_READ, 0, 0);
    send_word(KIND_READ, 4095, 0);
    send_word(KIND_LOAD_IN, 0, 32767);
    send_word(KIND_LOAD_W, 0, -32768);
    send_word(KIND_RUN, 0, 0);
    send_word(KIND_READ, 0, 0);
    send_word(KIND_LOAD_IN, 4095, -1);
    send_word(KIND_LOAD_W, 4095, 21845);
    send_word(KIND_LOAD_IN, 0, -32768);
    send_word(KIND_RUN, 4095, -1);
    send_word(KIND_READ, 0, 0);
    send_word(KIND_READ, 1, 0);
    last_run_cycles = 6;
    settle();

    // Oversized, then zero kernel, zero batch and the largest kernel
    set_config(16, 16, 16, 32, 32, 7);
    send_word(KIND_RUN, 0, 0);
    send_word(KIND_READ, 0, 0);
    settle();
    set_config(31, 31, 31, 63, 63, 7);
    send_word(KIND_RUN, 0, 0);
    send_word(KIND_READ, 4095, 0);
    settle();
    set_config(1, 1, 1, 2, 2, 0);
    start_run();
    send_word(KIND_READ, 0, 0);
    settle();
    set_config(0, 1, 1, 1, 1, 1);
    start_run();
    send_word(KIND_READ, 0, 0);
    settle();
    set_config(1, 1, 1, 1, 1, 7);
    start_run();
    send_word(KIND_READ, 0, 0);
    settle();

    // Random phases, cycling the idling modes
    for (phase = 0; phase < 13; phase++) begin
      case (phase % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 53; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 53; end
        default: begin send_gap_pct = 15; stall_pct = 15; end
      endcase
      if (phase == 12)
        set_config(16, 1, 1, 1, 1, 1);
      else
        set_config($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3),
                   $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 3));
      if (phase == 4) begin
        @(posedge clk);
        hold_req <= 1'b1;
        for (int n = 0; n < 40; n++) send_word(KIND_READ, $urandom_range(0, 8), 0);
      end
      random_items(120);
      settle();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
